### src/jpp_pkg.sv
// ----------------------------------------------------------------------------
// jpp_pkg
// Shared types and constants for the JPEG precision probe and its checker.
// ----------------------------------------------------------------------------
package jpp_pkg;

    localparam int BYTE_W    = 8;
    localparam int OUTCOME_W = 2;
    localparam int PREC_W    = 4;
    localparam int LEN_W     = 16;
    localparam int M_DATA_W  = 8;

    // Result codes carried in the outcome field
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_P8  = 2'd0,
        OUT_P12 = 2'd1,
        OUT_ERR = 2'd2
    } outcome_t;

    // Marker and value constants
    localparam logic [BYTE_W-1:0] MARK_PREFIX = 8'hFF;
    localparam logic [BYTE_W-1:0] MARK_SOI    = 8'hD8;
    localparam logic [BYTE_W-1:0] RST_MASK    = 8'hF8;
    localparam logic [BYTE_W-1:0] MARK_RST0   = 8'hD0;
    localparam logic [BYTE_W-1:0] MARK_EOI    = 8'hD9;
    localparam logic [BYTE_W-1:0] MARK_SOF0   = 8'hC0;
    localparam logic [BYTE_W-1:0] MARK_SOS    = 8'hDA;
    localparam logic [BYTE_W-1:0] PREC_8      = 8'd8;
    localparam logic [BYTE_W-1:0] PREC_12     = 8'd12;

    // Precision reported alongside each outcome code
    function automatic logic [PREC_W-1:0] precision_of(input outcome_t code);
        logic [PREC_W-1:0] p;
        unique case (code)
            OUT_P8:  p = PREC_W'(8);
            OUT_P12: p = PREC_W'(12);
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

### src/jpeg_precision_probe.sv
// ----------------------------------------------------------------------------
// jpeg_precision_probe
// Byte-serial probe that reports the sample precision of a JPEG stream.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one buffer byte per word in s_tdata, s_tuser marks the
//   first byte of a buffer (restarts the parse), s_tlast marks the final one.
//   Master stream: at most one result word per buffer, carrying the outcome
//   code and the precision found (8, 12, or 0 on error).
//   Throughput: one byte per cycle while s_tready is high. Each accepted byte
//   updates the registered parse phase; a deciding byte places its result in
//   the output register (m_tvalid), or in the skid word if it is full and stalled.
//   Stall: the output register is backed by one skid word, so a byte is still
//   taken while a result waits; s_tready drops only when both are full.
//   Reset: the parser goes idle and ignores bytes until one flagged as first;
//   both output words are emptied.
//   After a result the parser is idle again until the next first byte.
// ----------------------------------------------------------------------------
module jpeg_precision_probe (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [0:0] s_tuser,   // [0] first_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] outcome, [5:2] precision_bits, [7:6] zero
);

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_SOI_HIGH   = 4'd1,
        PH_SOI_LOW    = 4'd2,
        PH_SCAN       = 4'd3,
        PH_MARKER     = 4'd4,
        PH_SEG_LEN_HI = 4'd5,
        PH_SEG_LEN_LO = 4'd6,
        PH_SKIP       = 4'd7,
        PH_SOF_LEN_HI = 4'd8,
        PH_SOF_LEN_LO = 4'd9,
        PH_SOF_PREC   = 4'd10
    } phase_t;

    localparam int PAD_W = jpp_pkg::M_DATA_W - jpp_pkg::OUTCOME_W - jpp_pkg::PREC_W;

    phase_t                        phase_reg, phase_next, phase_cur;
    logic [jpp_pkg::LEN_W-1:0]     skip_reg, skip_next;
    logic [jpp_pkg::BYTE_W-1:0]    len_hi_reg, len_hi_next;
    logic [jpp_pkg::BYTE_W-1:0]    len_lo_reg, len_lo_next;
    logic [jpp_pkg::LEN_W-1:0]     seg_len;

    logic                          accept;
    logic                          res_valid;
    logic                          live;
    jpp_pkg::outcome_t             res_code;

    logic                          out_valid_reg, skid_valid_reg;
    logic [jpp_pkg::M_DATA_W-1:0]  out_data_reg, skid_data_reg;
    logic [jpp_pkg::M_DATA_W-1:0]  res_word;
    logic                          pop, push;

    assign accept = s_tvalid && s_tready;

    // Parse one byte: next phase and any deciding result
    always_comb
    begin
        phase_cur   = s_tuser[0] ? PH_SOI_HIGH : phase_reg;
        phase_next  = phase_cur;
        skip_next   = skip_reg;
        len_hi_next = len_hi_reg;
        len_lo_next = len_lo_reg;
        res_valid   = 1'b0;
        res_code    = jpp_pkg::OUT_ERR;
        live        = 1'b1;
        seg_len     = {len_hi_reg, s_tdata};
        unique case (phase_cur)
            PH_IDLE:
            begin
                live = 1'b0;
            end
            PH_SOI_HIGH:
            begin
                if (s_tdata == jpp_pkg::MARK_PREFIX) phase_next = PH_SOI_LOW;
                else res_valid = 1'b1;
            end
            PH_SOI_LOW:
            begin
                if (s_tdata == jpp_pkg::MARK_SOI) phase_next = PH_SCAN;
                else res_valid = 1'b1;
            end
            PH_SCAN:
            begin
                if (s_tdata == jpp_pkg::MARK_PREFIX) phase_next = PH_MARKER;
            end
            PH_MARKER:
            begin
                // Stand-alone markers resume the scan; SOS is fatal
                if ((s_tdata & jpp_pkg::RST_MASK) == jpp_pkg::MARK_RST0
                    || s_tdata == jpp_pkg::MARK_EOI
                    || s_tdata <= jpp_pkg::BYTE_W'(1))
                    phase_next = PH_SCAN;
                else if (s_tdata == jpp_pkg::MARK_SOF0)
                    phase_next = PH_SOF_LEN_HI;
                else if (s_tdata == jpp_pkg::MARK_SOS)
                    res_valid = 1'b1;
                else
                    phase_next = PH_SEG_LEN_HI;
            end
            PH_SEG_LEN_HI:
            begin
                len_hi_next = s_tdata;
                phase_next  = PH_SEG_LEN_LO;
            end
            PH_SEG_LEN_LO:
            begin
                len_lo_next = s_tdata;
                if (seg_len <= jpp_pkg::LEN_W'(2))
                begin
                    phase_next = PH_SCAN;
                end
                else
                begin
                    skip_next  = seg_len - jpp_pkg::LEN_W'(2);
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                // Count is never zero here: lengths above two only
                skip_next = skip_reg - jpp_pkg::LEN_W'(1);
                if (skip_reg == jpp_pkg::LEN_W'(1)) phase_next = PH_SCAN;
            end
            PH_SOF_LEN_HI:
            begin
                len_hi_next = s_tdata;
                phase_next  = PH_SOF_LEN_LO;
            end
            PH_SOF_LEN_LO:
            begin
                len_lo_next = s_tdata;
                phase_next  = PH_SOF_PREC;
            end
            PH_SOF_PREC:
            begin
                res_valid = 1'b1;
                if (!s_tlast && s_tdata == jpp_pkg::PREC_8) res_code = jpp_pkg::OUT_P8;
                else if (!s_tlast && s_tdata == jpp_pkg::PREC_12) res_code = jpp_pkg::OUT_P12;
            end
            default:
            begin
                live       = 1'b0;
                phase_next = PH_IDLE;
            end
        endcase
        // End of buffer without a decision
        if (live && s_tlast) res_valid = 1'b1;
        if (res_valid) phase_next = PH_IDLE;
    end

    assign res_word = {{PAD_W{1'b0}}, jpp_pkg::precision_of(res_code), res_code};

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            skip_reg   <= '0;
            len_hi_reg <= '0;
            len_lo_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            skip_reg   <= skip_next;
            len_hi_reg <= len_hi_next;
            len_lo_reg <= len_lo_next;
        end
    end

    assign pop  = out_valid_reg && m_tready;
    assign push = accept && res_valid;

    // Output word and skid word: refill from skid first, else from the parser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (pop || !out_valid_reg) out_valid_reg <= 1'b1;
            else skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop) out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (pop || !out_valid_reg) out_data_reg <= res_word;
            else skid_data_reg <= res_word;
        end
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### src/jpp_checker.sv
// ----------------------------------------------------------------------------
// jpp_checker
// Port-level checks for the JPEG precision probe, bound to the top level.
// ----------------------------------------------------------------------------
module jpp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // Hold a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed or vanished");

    // Back-pressure only while a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // Outcome code is a defined one and the padding is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:6] == 2'b00 && m_tdata[1:0] != 2'b11)
        else $error("malformed result word");

    // Precision agrees with the outcome code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[5:2] ==
            jpp_pkg::precision_of(jpp_pkg::outcome_t'(m_tdata[1:0])))
        else $error("precision does not match outcome");

endmodule

bind jpeg_precision_probe jpp_checker u_jpp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
